@@ sv/quad_attitude_pid_mixer_defines.svh @@
// ----------------------------------------------------------------------------
// Attitude PID mixer assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef QUAD_ATTITUDE_PID_MIXER_DEFINES_SVH
`define QUAD_ATTITUDE_PID_MIXER_DEFINES_SVH

// Same-cycle implication.
`define QAPM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define QAPM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/qapm_pkg.sv @@
// ----------------------------------------------------------------------------
// Attitude PID mixer package
// Transaction payload types, pipeline control struct and fixed constants.
// ----------------------------------------------------------------------------
package qapm_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_DEG  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_LOW    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_HIGH   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE     = 3'd6;

  localparam logic [15:0] GAIN_P_RST    = 16'd2048;
  localparam logic [15:0] GAIN_I_RST    = 16'd0;
  localparam logic [15:0] GAIN_D_RST    = 16'd410;
  localparam logic [8:0]  RESET_DEG_RST = 9'd40;
  localparam logic [15:0] THR_LOW_RST   = 16'd1065;
  localparam logic [15:0] THR_HIGH_RST  = 16'd1900;
  localparam logic [6:0]  SETTLE_RST    = 7'd100;

  localparam logic [15:0] YAW_CENTER   = 16'd1482;
  localparam logic [15:0] PITCH_CENTER = 16'd1535;
  localparam logic [15:0] ROLL_CENTER  = 16'd1485;
  localparam logic [16:0] ROLL_WRAP    = 17'd36000;

  typedef struct packed {
    logic [15:0]        throttle_pulse;
    logic [15:0]        yaw_pulse;
    logic [15:0]        pitch_pulse;
    logic [15:0]        roll_pulse;
    logic signed [15:0] yaw_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] roll_angle;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        motor_front_left;
    logic [15:0]        motor_front_right;
    logic [15:0]        motor_rear_left;
    logic [15:0]        motor_rear_right;
    logic signed [31:0] yaw_drive;
    logic signed [31:0] pitch_drive;
    logic signed [31:0] roll_drive;
  } out_item_t;

  typedef struct packed {
    logic [15:0] fl;
    logic [15:0] fr;
    logic [15:0] rl;
    logic [15:0] rr;
  } mix_t;

  typedef struct packed {
    logic step;
    logic load_prod;
  } axis_ctl_t;

endpackage

@@ sv/qapm_stream_if.sv @@
// ----------------------------------------------------------------------------
// Attitude PID mixer stream channel
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface qapm_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ sv/qapm_pid_axis.sv @@
// ----------------------------------------------------------------------------
// Attitude PID axis
// Error, integral and derivative update, gain products and rounded drive.
// ----------------------------------------------------------------------------
module qapm_pid_axis (
  input  logic                clk,
  input  logic                rst_n,
  input  qapm_pkg::axis_ctl_t ctl,
  input  logic [15:0]         gain_p,
  input  logic [15:0]         gain_i,
  input  logic [15:0]         gain_d,
  input  logic [8:0]          reset_deg,
  input  logic signed [16:0]  reference,
  input  logic signed [16:0]  current,
  output logic signed [31:0]  drive
);

  logic signed [16:0] err;
  logic [16:0]        mag;
  logic [16:0]        clr_thr;
  logic               clear;
  logic signed [32:0] isum;
  logic signed [31:0] isat;
  logic signed [31:0] integral_nxt;
  logic signed [17:0] deriv;

  logic signed [31:0] integral_r;
  logic signed [16:0] prev_err_r;

  logic signed [16:0] err_s1_r;
  logic signed [31:0] integ_s1_r;
  logic signed [17:0] deriv_s1_r;

  logic signed [33:0] prod_p;
  logic signed [48:0] prod_i;
  logic signed [34:0] prod_d;
  logic signed [33:0] prod_p_r;
  logic signed [48:0] prod_i_r;
  logic signed [34:0] prod_d_r;

  logic signed [50:0] sum;
  logic signed [38:0] quo;

  always_comb begin
    err     = reference - current;
    mag     = err[16] ? (~err + 17'd1) : err;
    clr_thr = ({8'd0, reset_deg} << 6) + ({8'd0, reset_deg} << 5)
            + ({8'd0, reset_deg} << 2) + 17'd99;
    clear   = (err == 17'sd0) || (mag > clr_thr);
    isum    = {integral_r[31], integral_r} + {{16{err[16]}}, err};
    if (isum[32] != isum[31]) begin
      isat = isum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      isat = isum[31:0];
    end
    integral_nxt = clear ? 32'sd0 : isat;
    deriv        = {err[16], err} - {prev_err_r[16], prev_err_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integral_r <= '0;
      prev_err_r <= '0;
    end else if (ctl.step) begin
      integral_r <= integral_nxt;
      prev_err_r <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      err_s1_r   <= err;
      integ_s1_r <= integral_nxt;
      deriv_s1_r <= deriv;
    end
  end

  always_comb begin
    prod_p = $signed({18'd0, gain_p}) * $signed({{17{err_s1_r[16]}}, err_s1_r});
    prod_i = $signed({33'd0, gain_i}) * $signed({{17{integ_s1_r[31]}}, integ_s1_r});
    prod_d = $signed({19'd0, gain_d}) * $signed({{17{deriv_s1_r[17]}}, deriv_s1_r});
  end

  always_ff @(posedge clk) begin
    if (ctl.load_prod) begin
      prod_p_r <= prod_p;
      prod_i_r <= prod_i;
      prod_d_r <= prod_d;
    end
  end

  always_comb begin
    sum = {{17{prod_p_r[33]}}, prod_p_r} + {{2{prod_i_r[48]}}, prod_i_r}
        + {{16{prod_d_r[34]}}, prod_d_r} + 51'sd2048;
    quo = sum[50:12];
    if ((quo[38:31] == 8'h00) || (quo[38:31] == 8'hFF)) begin
      drive = quo[31:0];
    end else begin
      drive = quo[38] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
  end

endmodule

@@ sv/quad_attitude_pid_mixer.sv @@
// ----------------------------------------------------------------------------
// Quadcopter attitude PID mixer
// Three-axis integer PID on measured angles with an X-frame motor mixer.
// ----------------------------------------------------------------------------
//   Port group   Direction   Carries
//   in_chan      sink        pulse widths and yaw, pitch, roll angles
//   out_chan     source      four motor pulses and three PID drives
//   cfg_*        input       write-only gain, limit and settle registers
//
// One transaction is accepted per clock while in_chan.ready is high; a sample
// inside the throttle window after the settle count is reached gives a result
// through the state-update, product and output registers behind the input
// register. Reset is synchronous and restores the register defaults, clears
// the integrals and references and sets the settle count to one. A stalled
// output fills the pipeline bubbles first; in_chan.ready falls only when all
// four stages hold data and out_chan is not ready.
`include "quad_attitude_pid_mixer_defines.svh"

module quad_attitude_pid_mixer (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [qapm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [qapm_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  qapm_stream_if.sink                        in_chan,
  qapm_stream_if.source                      out_chan
);

  logic [15:0] gain_p_r, gain_i_r, gain_d_r;
  logic [8:0]  reset_deg_r;
  logic [15:0] thr_low_r, thr_high_r;
  logic [6:0]  settle_r;

  logic [6:0]         settle_count_r;
  logic signed [15:0] ref_yaw_r;
  logic signed [15:0] ref_pitch_r;
  logic [16:0]        ref_roll_r;

  logic v0_r, v1_r, v2_r, vo_r;
  logic ld0, ld1, ld2, ld_o;
  logic take0, window_ok, capture, step_active, capture_take;

  qapm_pkg::in_item_t  in_r;
  qapm_pkg::mix_t      mix, mix_s1_r, mix_s2_r;
  qapm_pkg::out_item_t out_r;
  qapm_pkg::axis_ctl_t axis_ctl;

  logic [16:0]        roll_cur;
  logic [15:0]        yoff, poff, roff;
  logic signed [31:0] yaw_drv, pitch_drv, roll_drv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r    <= qapm_pkg::GAIN_P_RST;
      gain_i_r    <= qapm_pkg::GAIN_I_RST;
      gain_d_r    <= qapm_pkg::GAIN_D_RST;
      reset_deg_r <= qapm_pkg::RESET_DEG_RST;
      thr_low_r   <= qapm_pkg::THR_LOW_RST;
      thr_high_r  <= qapm_pkg::THR_HIGH_RST;
      settle_r    <= qapm_pkg::SETTLE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        qapm_pkg::CFG_GAIN_P:    gain_p_r    <= cfg_wdata;
        qapm_pkg::CFG_GAIN_I:    gain_i_r    <= cfg_wdata;
        qapm_pkg::CFG_GAIN_D:    gain_d_r    <= cfg_wdata;
        qapm_pkg::CFG_RESET_DEG: reset_deg_r <= cfg_wdata[8:0];
        qapm_pkg::CFG_THR_LOW:   thr_low_r   <= cfg_wdata;
        qapm_pkg::CFG_THR_HIGH:  thr_high_r  <= cfg_wdata;
        qapm_pkg::CFG_SETTLE:    settle_r    <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ld_o = !vo_r || out_chan.ready;
    ld2  = !v2_r || ld_o;
    ld1  = !v1_r || ld2;
    ld0  = !v0_r || ld1;
    take0 = v0_r && ld1;

    window_ok    = (thr_low_r < in_r.throttle_pulse) && (in_r.throttle_pulse < thr_high_r);
    capture      = settle_count_r < settle_r;
    step_active  = take0 && window_ok && !capture;
    capture_take = take0 && window_ok && capture;

    roll_cur = in_r.roll_angle[15]
             ? ({1'b1, in_r.roll_angle} + qapm_pkg::ROLL_WRAP)
             : {1'b0, in_r.roll_angle};

    yoff   = in_r.yaw_pulse - qapm_pkg::YAW_CENTER;
    poff   = in_r.pitch_pulse - qapm_pkg::PITCH_CENTER;
    roff   = in_r.roll_pulse - qapm_pkg::ROLL_CENTER;
    mix.fl = in_r.throttle_pulse - poff - roff + yoff;
    mix.fr = in_r.throttle_pulse - poff + roff - yoff;
    mix.rl = in_r.throttle_pulse + poff + roff - yoff;
    mix.rr = in_r.throttle_pulse + poff - roff + yoff;

    axis_ctl.step      = step_active;
    axis_ctl.load_prod = ld2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (ld0) v0_r <= in_chan.valid;
      if (ld1) v1_r <= step_active;
      if (ld2) v2_r <= v1_r;
      if (ld_o) vo_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_count_r <= 7'd1;
      ref_yaw_r      <= '0;
      ref_pitch_r    <= '0;
      ref_roll_r     <= '0;
    end else if (capture_take) begin
      settle_count_r <= settle_count_r + 7'd1;
      ref_yaw_r      <= in_r.yaw_angle;
      ref_pitch_r    <= in_r.pitch_angle;
      ref_roll_r     <= roll_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (ld0) in_r <= in_chan.payload;
    if (ld1) mix_s1_r <= mix;
    if (ld2) mix_s2_r <= mix_s1_r;
    if (ld_o) begin
      out_r.motor_front_left  <= mix_s2_r.fl;
      out_r.motor_front_right <= mix_s2_r.fr;
      out_r.motor_rear_left   <= mix_s2_r.rl;
      out_r.motor_rear_right  <= mix_s2_r.rr;
      out_r.yaw_drive         <= yaw_drv;
      out_r.pitch_drive       <= pitch_drv;
      out_r.roll_drive        <= roll_drv;
    end
  end

  qapm_pid_axis u_yaw (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (axis_ctl),
    .gain_p    (gain_p_r),
    .gain_i    (gain_i_r),
    .gain_d    (gain_d_r),
    .reset_deg (reset_deg_r),
    .reference ({ref_yaw_r[15], ref_yaw_r}),
    .current   ({in_r.yaw_angle[15], in_r.yaw_angle}),
    .drive     (yaw_drv)
  );

  qapm_pid_axis u_pitch (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (axis_ctl),
    .gain_p    (gain_p_r),
    .gain_i    (gain_i_r),
    .gain_d    (gain_d_r),
    .reset_deg (reset_deg_r),
    .reference ({ref_pitch_r[15], ref_pitch_r}),
    .current   ({in_r.pitch_angle[15], in_r.pitch_angle}),
    .drive     (pitch_drv)
  );

  qapm_pid_axis u_roll (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (axis_ctl),
    .gain_p    (gain_p_r),
    .gain_i    (gain_i_r),
    .gain_d    (gain_d_r),
    .reset_deg (reset_deg_r),
    .reference ($signed(ref_roll_r)),
    .current   ($signed(roll_cur)),
    .drive     (roll_drv)
  );

  assign in_chan.ready    = ld0;
  assign out_chan.valid   = vo_r;
  assign out_chan.payload = out_r;

  `QAPM_ASSERT_NXT(a_capture_count, capture_take, settle_count_r == $past(settle_count_r) + 7'd1, "settle count did not advance on capture")
  `QAPM_ASSERT_NXT(a_idle_sample, take0 && !window_ok, $stable(settle_count_r) && $stable(ref_roll_r), "state changed on a sample outside the throttle window")
  `QAPM_ASSERT_IMP(a_full_stall, !ld0, v0_r && v1_r && v2_r && vo_r && !out_chan.ready, "input stalled with a pipeline bubble")

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// Attitude PID mixer testbench
// Drives pulse and angle samples into the mixer with random gaps on both
// channels and reprograms the gain, limit and settle registers between
// phases. A scoreboard predicts the motor and drive outputs and compares
// every output transaction with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

  localparam int AXIS_YAW   = 0;
  localparam int AXIS_PITCH = 1;
  localparam int AXIS_ROLL  = 2;

  localparam logic [qapm_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  localparam longint DRIVE_TOP    = 64'sd2147483647;
  localparam longint DRIVE_BOTTOM = -64'sd2147483648;

  localparam int unsigned SETTLE_WAIT = 70;
  localparam int unsigned SAT_ITEMS   = 40;

  class attitude_scoreboard;
    logic [15:0]         gain_p;
    logic [15:0]         gain_i;
    logic [15:0]         gain_d;
    logic [8:0]          reset_deg;
    logic [15:0]         thr_low;
    logic [15:0]         thr_high;
    logic [6:0]          settle_target;
    logic [6:0]          settle_count;
    int                  ref_angle[3];
    int                  integral[3];
    int                  last_error[3];
    qapm_pkg::out_item_t motor_commands_due[$];
    int unsigned         mismatches;

    function new();
      gain_p        = qapm_pkg::GAIN_P_RST;
      gain_i        = qapm_pkg::GAIN_I_RST;
      gain_d        = qapm_pkg::GAIN_D_RST;
      reset_deg     = qapm_pkg::RESET_DEG_RST;
      thr_low       = qapm_pkg::THR_LOW_RST;
      thr_high      = qapm_pkg::THR_HIGH_RST;
      settle_target = qapm_pkg::SETTLE_RST;
      settle_count  = 7'd1;
      foreach (ref_angle[k]) begin
        ref_angle[k]  = 0;
        integral[k]   = 0;
        last_error[k] = 0;
      end
      mismatches = 0;
    endfunction

    function void apply_register(logic [qapm_pkg::CFG_IDX_W-1:0] idx,
                                 logic [qapm_pkg::CFG_DATA_W-1:0] value);
      case (idx)
        qapm_pkg::CFG_GAIN_P:    gain_p = value;
        qapm_pkg::CFG_GAIN_I:    gain_i = value;
        qapm_pkg::CFG_GAIN_D:    gain_d = value;
        qapm_pkg::CFG_RESET_DEG: reset_deg = value[8:0];
        qapm_pkg::CFG_THR_LOW:   thr_low = value;
        qapm_pkg::CFG_THR_HIGH:  thr_high = value;
        qapm_pkg::CFG_SETTLE:    settle_target = value[6:0];
        default: ;
      endcase
    endfunction

    function bit window_open(logic [15:0] thr);
      return (thr_low < thr) && (thr < thr_high);
    endfunction

    function int clamp32(longint v);
      if (v > DRIVE_TOP) begin
        return int'(DRIVE_TOP);
      end
      if (v < DRIVE_BOTTOM) begin
        return int'(DRIVE_BOTTOM);
      end
      return int'(v);
    endfunction

    function int axis_drive(int axis, int err);
      longint acc;
      longint total;
      int     slope;
      int     mag;
      acc = longint'(clamp32(longint'(integral[axis]) + longint'(err)));
      slope = err - last_error[axis];
      last_error[axis] = err;
      mag = (err < 0) ? -err : err;
      if (err == 0 || mag / 100 > int'(reset_deg)) begin
        acc = 0;
      end
      integral[axis] = int'(acc);
      total = longint'(gain_p) * longint'(err) + longint'(gain_i) * acc
            + longint'(gain_d) * longint'(slope) + 64'sd2048;
      return clamp32(total >>> 12);
    endfunction

    function void note_sample(qapm_pkg::in_item_t s);
      int                  angle[3];
      qapm_pkg::out_item_t e;
      logic [15:0]         yaw_off;
      logic [15:0]         pitch_off;
      logic [15:0]         roll_off;
      if (!window_open(s.throttle_pulse)) begin
        return;
      end
      angle[AXIS_YAW]   = int'(s.yaw_angle);
      angle[AXIS_PITCH] = int'(s.pitch_angle);
      angle[AXIS_ROLL]  = int'(s.roll_angle);
      if (angle[AXIS_ROLL] < 0) begin
        angle[AXIS_ROLL] += int'(qapm_pkg::ROLL_WRAP);
      end
      if (settle_count < settle_target) begin
        settle_count++;
        ref_angle = angle;
        return;
      end
      e.yaw_drive   = axis_drive(AXIS_YAW, ref_angle[AXIS_YAW] - angle[AXIS_YAW]);
      e.pitch_drive = axis_drive(AXIS_PITCH, ref_angle[AXIS_PITCH] - angle[AXIS_PITCH]);
      e.roll_drive  = axis_drive(AXIS_ROLL, ref_angle[AXIS_ROLL] - angle[AXIS_ROLL]);
      yaw_off   = s.yaw_pulse - qapm_pkg::YAW_CENTER;
      pitch_off = s.pitch_pulse - qapm_pkg::PITCH_CENTER;
      roll_off  = s.roll_pulse - qapm_pkg::ROLL_CENTER;
      e.motor_front_left  = s.throttle_pulse - pitch_off - roll_off + yaw_off;
      e.motor_front_right = s.throttle_pulse - pitch_off + roll_off - yaw_off;
      e.motor_rear_left   = s.throttle_pulse + pitch_off + roll_off - yaw_off;
      e.motor_rear_right  = s.throttle_pulse + pitch_off - roll_off + yaw_off;
      motor_commands_due.push_back(e);
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("%0t mismatch: %s", $time, what);
    endtask

    task compare_field(string field, logic [31:0] got, logic [31:0] want);
      if (got !== want) begin
        report_mismatch($sformatf("%s got %h expected %h", field, got, want));
      end
    endtask

    task check_command(qapm_pkg::out_item_t got);
      qapm_pkg::out_item_t want;
      if (motor_commands_due.size() == 0) begin
        report_mismatch("output transaction with no prediction pending");
        return;
      end
      want = motor_commands_due.pop_front();
      compare_field("motor_front_left", 32'(got.motor_front_left),
                    32'(want.motor_front_left));
      compare_field("motor_front_right", 32'(got.motor_front_right),
                    32'(want.motor_front_right));
      compare_field("motor_rear_left", 32'(got.motor_rear_left),
                    32'(want.motor_rear_left));
      compare_field("motor_rear_right", 32'(got.motor_rear_right),
                    32'(want.motor_rear_right));
      compare_field("yaw_drive", got.yaw_drive, want.yaw_drive);
      compare_field("pitch_drive", got.pitch_drive, want.pitch_drive);
      compare_field("roll_drive", got.roll_drive, want.roll_drive);
    endtask
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            cfg_we;
  logic [qapm_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [qapm_pkg::CFG_DATA_W-1:0] cfg_wdata;

  qapm_stream_if #(.payload_t(qapm_pkg::in_item_t))  in_if ();
  qapm_stream_if #(.payload_t(qapm_pkg::out_item_t)) out_if ();

  attitude_scoreboard sb = new();

  bit          steady_flow = 1'b0;
  int unsigned ready_left = 0;
  int          base_yaw;
  int          base_pitch;
  int          base_roll;

  quad_attitude_pid_mixer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_if),
    .out_chan  (out_if)
  );

  always #5 clk = ~clk;

  function automatic int unsigned pick_gap();
    int unsigned r = $urandom_range(0, 99);
    if (r < 80) begin
      return $urandom_range(1, 3);
    end
    if (r < 95) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      ready_left   <= 0;
    end else if (ready_left != 0) begin
      ready_left <= ready_left - 1;
    end else if (steady_flow || $urandom_range(0, 2) != 0) begin
      out_if.ready <= 1'b1;
      ready_left <= $urandom_range(0, 8);
    end else begin
      out_if.ready <= 1'b0;
      ready_left <= pick_gap() - 1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      sb.check_command(out_if.payload);
    end
  end

  function automatic logic [15:0] pick_pulse();
    if ($urandom_range(0, 3) != 0) begin
      return 16'($urandom_range(1000, 2000));
    end
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [15:0] pick_angle(int base);
    case ($urandom_range(0, 9))
      0: return 16'($urandom_range(0, 65535));
      1: return 16'(int'($urandom_range(0, 36000)) - 18000);
      2: return 16'(base);
      default: return 16'(base + int'($urandom_range(0, 6000)) - 3000);
    endcase
  endfunction

  function automatic qapm_pkg::in_item_t make_sample(bit armed);
    qapm_pkg::in_item_t s;
    int                 lo = int'(sb.thr_low);
    int                 hi = int'(sb.thr_high);
    s.throttle_pulse = 16'($urandom_range(0, 65535));
    if (armed && hi - lo >= 2) begin
      s.throttle_pulse = 16'($urandom_range(lo + 1, hi - 1));
    end
    s.yaw_pulse   = pick_pulse();
    s.pitch_pulse = pick_pulse();
    s.roll_pulse  = pick_pulse();
    s.yaw_angle   = pick_angle(base_yaw);
    s.pitch_angle = pick_angle(base_pitch);
    s.roll_angle  = pick_angle(base_roll);
    return s;
  endfunction

  task automatic choose_attitude();
    base_yaw   = int'($urandom_range(0, 30000)) - 15000;
    base_pitch = int'($urandom_range(0, 30000)) - 15000;
    base_roll  = int'($urandom_range(0, 30000)) - 15000;
  endtask

  task automatic send_sample(qapm_pkg::in_item_t s);
    if (!steady_flow && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= s;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_sample(s);
  endtask

  task automatic run_stream(int unsigned armed_goal);
    int unsigned        armed_seen = 0;
    qapm_pkg::in_item_t s;
    while (armed_seen < armed_goal) begin
      s = make_sample($urandom_range(0, 9) != 0);
      if (sb.window_open(s.throttle_pulse)) begin
        armed_seen++;
      end
      send_sample(s);
    end
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.motor_commands_due.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic program_register(logic [qapm_pkg::CFG_IDX_W-1:0] idx,
                                  logic [qapm_pkg::CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    sb.apply_register(idx, value);
  endtask

  task automatic program_gains(logic [15:0] p, logic [15:0] i, logic [15:0] d);
    program_register(qapm_pkg::CFG_GAIN_P, p);
    program_register(qapm_pkg::CFG_GAIN_I, i);
    program_register(qapm_pkg::CFG_GAIN_D, d);
  endtask

  task automatic send_held_attitude(int unsigned count);
    repeat (count) begin
      send_sample(qapm_pkg::in_item_t'{16'($urandom_range(1, 65534)), 16'($urandom),
                                       16'($urandom), 16'($urandom), -16'sd6099,
                                       16'sd6099, 16'($urandom)});
    end
  endtask

  initial begin
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= '0;
    cfg_wdata     <= '0;
    in_if.valid   <= 1'b0;
    in_if.payload <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: window edges, capture, angle and pulse extremes.
    program_register(qapm_pkg::CFG_SETTLE, 16'd3);
    send_sample(qapm_pkg::in_item_t'{16'd0, qapm_pkg::YAW_CENTER, qapm_pkg::PITCH_CENTER,
                                     qapm_pkg::ROLL_CENTER, 16'sd0, 16'sd0, 16'sd0});
    send_sample(qapm_pkg::in_item_t'{qapm_pkg::THR_LOW_RST, qapm_pkg::YAW_CENTER,
                                     qapm_pkg::PITCH_CENTER, qapm_pkg::ROLL_CENTER,
                                     16'sd0, 16'sd0, 16'sd0});
    send_sample(qapm_pkg::in_item_t'{qapm_pkg::THR_HIGH_RST, qapm_pkg::YAW_CENTER,
                                     qapm_pkg::PITCH_CENTER, qapm_pkg::ROLL_CENTER,
                                     16'sd0, 16'sd0, 16'sd0});
    send_sample(qapm_pkg::in_item_t'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                     16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
    send_sample(qapm_pkg::in_item_t'{16'd1066, qapm_pkg::YAW_CENTER, qapm_pkg::PITCH_CENTER,
                                     qapm_pkg::ROLL_CENTER, 16'sd1000, -16'sd2000,
                                     -16'sd500});
    send_sample(qapm_pkg::in_item_t'{16'd1899, qapm_pkg::YAW_CENTER, qapm_pkg::PITCH_CENTER,
                                     qapm_pkg::ROLL_CENTER, 16'sd30000, -16'sd30000,
                                     -16'sd1});
    send_sample(qapm_pkg::in_item_t'{16'd1500, qapm_pkg::YAW_CENTER, qapm_pkg::PITCH_CENTER,
                                     qapm_pkg::ROLL_CENTER, 16'sd30000, -16'sd30000,
                                     -16'sd1});
    send_sample(qapm_pkg::in_item_t'{16'd1066, 16'h0000, 16'h0000, 16'h0000,
                                     16'sh8000, 16'sh7FFF, 16'sd0});
    send_sample(qapm_pkg::in_item_t'{16'd1899, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                     16'sh7FFF, 16'sh8000, 16'sh8000});
    send_sample(qapm_pkg::in_item_t'{16'd1500, 16'd1000, 16'd2000, 16'd1700,
                                     16'sd29990, -16'sd29995, -16'sd100});
    repeat (2) begin
      send_sample(qapm_pkg::in_item_t'{16'd1700, 16'd1482, 16'd1600, 16'd1400,
                                       16'sd25901, -16'sd25900, -16'sd200});
    end
    drain();
    program_gains(16'hFFFF, 16'hFFFF, 16'hFFFF);
    program_register(qapm_pkg::CFG_RESET_DEG, 16'd360);
    program_register(CFG_SPARE, 16'hFFFF);
    repeat (2) begin
      send_sample(qapm_pkg::in_item_t'{16'd1300, 16'd2000, 16'd1000, qapm_pkg::ROLL_CENTER,
                                       -16'sd6099, 16'sd6100, 16'sd0});
    end
    send_sample(qapm_pkg::in_item_t'{16'd1300, qapm_pkg::YAW_CENTER, qapm_pkg::PITCH_CENTER,
                                     qapm_pkg::ROLL_CENTER, 16'sd30000, -16'sd30000,
                                     -16'sd1});
    drain();
    program_gains(16'd0, 16'd0, 16'd0);
    program_register(qapm_pkg::CFG_RESET_DEG, 16'd0);
    send_sample(qapm_pkg::in_item_t'{16'd1500, qapm_pkg::YAW_CENTER, qapm_pkg::PITCH_CENTER,
                                     qapm_pkg::ROLL_CENTER, 16'sd29901, -16'sd29900,
                                     -16'sd2});
    drain();
    program_register(qapm_pkg::CFG_THR_LOW, 16'd2000);
    program_register(qapm_pkg::CFG_THR_HIGH, 16'd1000);
    send_sample(qapm_pkg::in_item_t'{16'd1500, qapm_pkg::YAW_CENTER, qapm_pkg::PITCH_CENTER,
                                     qapm_pkg::ROLL_CENTER, 16'sd0, 16'sd0, 16'sd0});
    send_sample(qapm_pkg::in_item_t'{16'hFFFF, qapm_pkg::YAW_CENTER, qapm_pkg::PITCH_CENTER,
                                     qapm_pkg::ROLL_CENTER, 16'sd0, 16'sd0, 16'sd0});
    send_sample(qapm_pkg::in_item_t'{16'd0, qapm_pkg::YAW_CENTER, qapm_pkg::PITCH_CENTER,
                                     qapm_pkg::ROLL_CENTER, 16'sd0, 16'sd0, 16'sd0});
    drain();
    program_register(qapm_pkg::CFG_THR_LOW, 16'd0);
    program_register(qapm_pkg::CFG_THR_HIGH, 16'hFFFF);
    send_sample(qapm_pkg::in_item_t'{16'd0, 16'hFFFF, 16'h0000, 16'hFFFF,
                                     16'sd30000, -16'sd30000, -16'sd1});
    send_sample(qapm_pkg::in_item_t'{16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF,
                                     16'sd30000, -16'sd30000, -16'sd1});
    send_sample(qapm_pkg::in_item_t'{16'd1, 16'hFFFF, 16'h0000, 16'hFFFF,
                                     16'sd30000, -16'sd30000, -16'sd1});
    send_sample(qapm_pkg::in_item_t'{16'hFFFE, 16'h0000, 16'hFFFF, 16'h0000,
                                     16'sd30000, -16'sd30000, -16'sd1});

    // Hold a constant yaw and pitch error so those integrals build up, then raise
    // the gains to their maximum.
    drain();
    program_gains(16'd1, 16'd1, 16'd1);
    program_register(qapm_pkg::CFG_RESET_DEG, 16'd360);
    steady_flow = 1'b1;
    send_held_attitude(SAT_ITEMS);
    steady_flow = 1'b0;
    drain();
    program_gains(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_held_attitude(4);

    // Random phases; the first sets upper register bits to check the masking.
    drain();
    program_register(qapm_pkg::CFG_SETTLE, 16'hFF64);
    program_register(qapm_pkg::CFG_RESET_DEG, 16'hFE28);
    program_gains(qapm_pkg::GAIN_P_RST, 16'd64, qapm_pkg::GAIN_D_RST);
    program_register(qapm_pkg::CFG_THR_LOW, qapm_pkg::THR_LOW_RST);
    program_register(qapm_pkg::CFG_THR_HIGH, qapm_pkg::THR_HIGH_RST);
    choose_attitude();
    run_stream(160);

    drain();
    program_register(qapm_pkg::CFG_SETTLE, 16'd127);
    program_gains(16'($urandom), 16'($urandom), 16'($urandom));
    program_register(qapm_pkg::CFG_RESET_DEG, 16'($urandom_range(0, 360)));
    program_register(qapm_pkg::CFG_THR_LOW, 16'($urandom_range(0, 1400)));
    program_register(qapm_pkg::CFG_THR_HIGH, 16'($urandom_range(1600, 65535)));
    choose_attitude();
    run_stream(120);

    drain();
    program_register(qapm_pkg::CFG_SETTLE, 16'd0);
    program_gains(16'($urandom_range(0, 8192)), 16'($urandom_range(0, 512)),
                  16'($urandom_range(0, 4096)));
    program_register(qapm_pkg::CFG_RESET_DEG, 16'd40);
    program_register(qapm_pkg::CFG_THR_LOW, 16'd1000);
    program_register(qapm_pkg::CFG_THR_HIGH, 16'd2000);
    choose_attitude();
    steady_flow = 1'b1;
    run_stream(60);
    steady_flow = 1'b0;
    run_stream(60);

    drain();
    program_register(qapm_pkg::CFG_SETTLE, 16'd50);
    program_gains(16'hFFFF, 16'hFFFF, 16'hFFFF);
    program_register(qapm_pkg::CFG_RESET_DEG, 16'd360);
    program_register(qapm_pkg::CFG_THR_LOW, 16'd0);
    program_register(qapm_pkg::CFG_THR_HIGH, 16'hFFFF);
    choose_attitude();
    run_stream(80);

    drain();
    if (sb.mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/qapm_pkg.sv
sv/qapm_stream_if.sv
sv/qapm_pid_axis.sv
sv/quad_attitude_pid_mixer.sv
tb/sv/tb_top.sv
